### rtl/gmc_pkg.sv
// ----------------------------------------------------------------------------
// gmc_pkg
// Shared types, codes and helpers for the gate motor controller.
// ----------------------------------------------------------------------------
package gmc_pkg;

	// elapsed-time counter width and configuration register width
	localparam int TIME_BITS = 24;
	localparam int CFG_BITS  = 24;
	localparam int CMP_BITS  = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;

	// configuration reset values
	localparam logic [CFG_BITS-1:0] STOP_WAIT_RST  = CFG_BITS'(1000);
	localparam logic [CFG_BITS-1:0] RETRY_WAIT_RST = CFG_BITS'(1000);
	localparam logic [CFG_BITS-1:0] TIMEOUT_RST    = CFG_BITS'(60000);

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_STOP_WAIT  = 2'd0,
		REG_RETRY_WAIT = 2'd1,
		REG_TIMEOUT    = 2'd2
	} reg_idx_t;

	// item modes
	typedef enum logic [2:0] {
		MODE_TICK   = 3'd0,
		MODE_OPEN   = 3'd1,
		MODE_CLOSE  = 3'd2,
		MODE_CANCEL = 3'd3,
		MODE_SET    = 3'd4
	} mode_t;

	// motor phases
	typedef enum logic [2:0] {
		PH_IDLE         = 3'd0,
		PH_OPEN_START   = 3'd1,
		PH_OPEN_MOVING  = 3'd2,
		PH_CLOSE_START  = 3'd3,
		PH_CLOSE_MOVING = 3'd4,
		PH_RETRY_WAIT   = 3'd5,
		PH_STOP_WAIT    = 3'd6
	} phase_t;

	// stop event codes
	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_REACHED = 3'd1,
		EV_LIMIT   = 3'd2,
		EV_TIMEOUT = 3'd3,
		EV_CANCEL  = 3'd4,
		EV_RETRY   = 3'd5
	} event_t;

	// one input beat
	typedef struct packed {
		logic [2:0]          mode;
		logic [CFG_BITS-1:0] run_ms;
		logic                switch_open;
		logic                switch_closed;
	} item_t;

	// configuration registers as seen by the step logic
	typedef struct packed {
		logic [CFG_BITS-1:0] stop_wait;
		logic [CFG_BITS-1:0] retry_wait;
		logic [CFG_BITS-1:0] timeout;
	} cfg_t;

	// controller state
	typedef struct packed {
		phase_t               phase;
		logic [TIME_BITS-1:0] since_start;
		logic [TIME_BITS-1:0] since_stop;
		logic [CFG_BITS-1:0]  run_limit;
		logic                 last_dir_close;
		logic                 relay_open;
		logic                 relay_close;
	} state_t;

	// one result beat
	typedef struct packed {
		logic   relay_open;
		logic   relay_close;
		phase_t phase;
		event_t stop_event;
		logic   rejected;
	} result_t;

	// saturating increment of an elapsed counter
	function automatic logic [TIME_BITS-1:0] sat_inc(input logic [TIME_BITS-1:0] v);
		return (&v) ? v : v + TIME_BITS'(1);
	endfunction

	// elapsed time strictly past a configured limit
	function automatic logic time_past(input logic [TIME_BITS-1:0] t,
		input logic [CFG_BITS-1:0] lim);
		return CMP_BITS'(t) > CMP_BITS'(lim);
	endfunction

endpackage

### rtl/gmc_step.sv
// ----------------------------------------------------------------------------
// gmc_step
// Next-state and result logic for one item of the gate motor controller.
// ----------------------------------------------------------------------------
module gmc_step import gmc_pkg::*; (
	input  state_t  st,
	input  item_t   item,
	input  cfg_t    cfg,
	output state_t  nxt,
	output result_t res
);

	logic [TIME_BITS-1:0] start_inc;
	logic [TIME_BITS-1:0] stop_inc;
	logic                 closing;
	logic                 moving;
	logic                 own_sw;
	logic                 opp_sw;
	event_t               ev;
	logic                 rej;

	assign start_inc = sat_inc(st.since_start);
	assign stop_inc  = sat_inc(st.since_stop);
	assign closing   = (st.phase == PH_CLOSE_START) || (st.phase == PH_CLOSE_MOVING);
	assign moving    = (st.phase == PH_OPEN_MOVING) || (st.phase == PH_CLOSE_MOVING);
	assign own_sw    = closing ? item.switch_closed : item.switch_open;
	assign opp_sw    = closing ? item.switch_open : item.switch_closed;

	// mode dispatch and phase handling
	always_comb begin
		nxt = st;
		ev  = EV_NONE;
		rej = 1'b0;
		case (item.mode)
			MODE_TICK: begin
				nxt.since_start = start_inc;
				nxt.since_stop  = stop_inc;
				case (st.phase)
					PH_OPEN_START, PH_OPEN_MOVING, PH_CLOSE_START, PH_CLOSE_MOVING: begin
						if (time_past(start_inc, st.run_limit)) begin
							ev = EV_REACHED;
						end else if (time_past(start_inc, cfg.timeout)) begin
							ev = EV_TIMEOUT;
						end else if (own_sw) begin
							ev = EV_LIMIT;
						end else if (moving && opp_sw) begin
							ev = EV_RETRY;
						end else if (!moving && !opp_sw) begin
							nxt.phase = closing ? PH_CLOSE_MOVING : PH_OPEN_MOVING;
						end
						// any stop drops both relays and restarts the stop timer
						if (ev != EV_NONE) begin
							nxt.since_stop  = '0;
							nxt.relay_open  = 1'b0;
							nxt.relay_close = 1'b0;
							nxt.phase       = (ev == EV_RETRY) ? PH_RETRY_WAIT : PH_STOP_WAIT;
						end
					end
					PH_RETRY_WAIT: begin
						if (time_past(stop_inc, cfg.retry_wait)) begin
							nxt.since_start = '0;
							nxt.relay_open  = !st.last_dir_close;
							nxt.relay_close = st.last_dir_close;
							nxt.phase       = st.last_dir_close ? PH_CLOSE_START
							                                    : PH_OPEN_START;
						end
					end
					PH_STOP_WAIT: begin
						if (time_past(stop_inc, cfg.stop_wait)) begin
							nxt.phase = PH_IDLE;
						end
					end
					default: begin
					end
				endcase
			end
			MODE_OPEN, MODE_CLOSE: begin
				if (st.phase == PH_IDLE) begin
					nxt.since_start    = '0;
					nxt.run_limit      = item.run_ms;
					nxt.last_dir_close = (item.mode == MODE_CLOSE);
					nxt.relay_open     = (item.mode == MODE_OPEN);
					nxt.relay_close    = (item.mode == MODE_CLOSE);
					nxt.phase          = (item.mode == MODE_CLOSE) ? PH_CLOSE_START
					                                               : PH_OPEN_START;
				end else begin
					rej = 1'b1;
				end
			end
			MODE_CANCEL: begin
				ev              = EV_CANCEL;
				nxt.since_stop  = '0;
				nxt.relay_open  = 1'b0;
				nxt.relay_close = 1'b0;
				nxt.phase       = PH_STOP_WAIT;
			end
			MODE_SET: begin
				nxt.run_limit = item.run_ms;
			end
			default: begin
			end
		endcase
	end

	// result reflects the state after the item
	always_comb begin
		res.relay_open  = nxt.relay_open;
		res.relay_close = nxt.relay_close;
		res.phase       = nxt.phase;
		res.stop_event  = ev;
		res.rejected    = rej;
	end

endmodule

### rtl/gate_motor_controller.sv
// ----------------------------------------------------------------------------
// gate_motor_controller
// Open/close relay sequencing for a single gate motor with limit switches.
// ----------------------------------------------------------------------------
// One result beat comes out for every input beat, in order. A beat is taken
// into an input register and evaluated against the controller state in one
// pass. The result lands in the output register when the input register
// advances, held off while a stalled result sits there. The input register
// and the output register each free up as soon as the next stage takes their
// content, so a new beat can be accepted in every cycle while out_ready stays
// high. Configuration writes take effect at once and belong to idle periods
// between beats.
module gate_motor_controller import gmc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// configuration write port
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data,
	// input channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          mode,
	input  logic [CFG_BITS-1:0] run_ms,
	input  logic                switch_open,
	input  logic                switch_closed,
	// result channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic                relay_open,
	output logic                relay_close,
	output logic [2:0]          phase,
	output logic [2:0]          stop_event,
	output logic                rejected
);

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	result_t res_nxt;
	logic    valid_s2;
	logic    adv_s1;
	logic    take_in;

	// handshake control
	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign take_in  = in_valid && in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stop_wait  <= STOP_WAIT_RST;
			cfg_q.retry_wait <= RETRY_WAIT_RST;
			cfg_q.timeout    <= TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STOP_WAIT:  cfg_q.stop_wait  <= cfg_data;
				REG_RETRY_WAIT: cfg_q.retry_wait <= cfg_data;
				REG_TIMEOUT:    cfg_q.timeout    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1.mode          <= mode;
			item_s1.run_ms        <= run_ms;
			item_s1.switch_open   <= switch_open;
			item_s1.switch_closed <= switch_closed;
		end
	end

	// single-pass evaluation
	gmc_step u_step (
		.st   (state_q),
		.item (item_s1),
		.cfg  (cfg_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase          <= PH_IDLE;
			state_q.since_start    <= '0;
			state_q.since_stop     <= '0;
			state_q.run_limit      <= '0;
			state_q.last_dir_close <= 1'b0;
			state_q.relay_open     <= 1'b0;
			state_q.relay_close    <= 1'b0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid   = valid_s2;
	assign relay_open  = res_s2.relay_open;
	assign relay_close = res_s2.relay_close;
	assign phase       = res_s2.phase;
	assign stop_event  = res_s2.stop_event;
	assign rejected    = res_s2.rejected;

endmodule

### rtl/gmc_checker.sv
// ----------------------------------------------------------------------------
// gmc_checker
// Port-level checks on the gate motor controller result stream.
// ----------------------------------------------------------------------------
module gmc_checker import gmc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       relay_open,
	input logic       relay_close,
	input logic [2:0] phase,
	input logic [2:0] stop_event,
	input logic       rejected
);

	// never drive both relays
	a_relay_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(relay_open && relay_close))
		else $error("both relays driven");

	// a stop always leaves both relays off
	a_stop_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (stop_event != EV_NONE) |-> !relay_open && !relay_close)
		else $error("relay on after stop event");

	// retry stop goes to retry wait, other stops to stop wait
	a_stop_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (stop_event != EV_NONE) |->
		((stop_event == EV_RETRY) ? (phase == PH_RETRY_WAIT) : (phase == PH_STOP_WAIT)))
		else $error("stop event and phase disagree");

	// a rejected command reports no stop
	a_rej_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> (stop_event == EV_NONE))
		else $error("rejected beat carries a stop event");

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(phase) && $stable(stop_event))
		else $error("stalled result beat changed");

endmodule

bind gate_motor_controller gmc_checker u_gmc_checker (.*);
